// File: hdl/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types, command codes and defaults of the price-level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int ORDER_SLOTS_DEF = 1024;
    localparam int MAX_LEVELS_DEF  = 256;

    localparam logic [31:0] ASK_EMPTY = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_REPLACE = 3'd1;
    localparam logic [2:0] CMD_CANCEL  = 3'd2;
    localparam logic [2:0] CMD_EXECUTE = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;
    localparam logic [2:0] CMD_RSV_A   = 3'd6;
    localparam logic [2:0] CMD_RSV_B   = 3'd7;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN  = 2'd1;
    localparam logic [1:0] STAT_ORD_FULL = 2'd2;
    localparam logic [1:0] STAT_LVL_FULL = 2'd3;

    localparam logic [1:0] LOP_NONE = 2'd0;
    localparam logic [1:0] LOP_TAKE = 2'd1;
    localparam logic [1:0] LOP_ADD  = 2'd2;
    localparam logic [1:0] LOP_READ = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [63:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } t_order_ent;

    typedef struct packed {
        logic [31:0] price;
        logic [63:0] size;
    } t_level_ent;

    typedef struct packed {
        logic [1:0]  op;
        logic        side;
        logic [31:0] price;
        logic [31:0] amount;
        logic [7:0]  idx;
    } t_lvl_req;

    typedef struct packed {
        logic        done;
        logic        full;
        logic [63:0] left;
    } t_lvl_rsp;

    typedef struct packed {
        logic [31:0] bid_px;
        logic [63:0] bid_sz;
        logic [31:0] ask_px;
        logic [63:0] ask_sz;
        logic [31:0] mid;
    } t_lvl_qry;

endpackage

// File: hdl/price_level_order_book_unit.sv
// ----------------------------------------------------------------------------
// price_level_order_book_unit
// Order table with bid and ask price-level aggregation.
// ----------------------------------------------------------------------------
// Usage: drive a command beat on the i_ ports with start high; it is taken
// at the edge where busy is low. busy stays high until the result beat,
// which appears for exactly one cycle with o_valid high; o_valid cannot be
// held off, so capture it on that edge.
// Sequencing: the order table is walked one entry at a time, read then checked
// (a lookup ends early on a match); the level table is searched and shifted
// one entry at a time. Replace does two lookups. A level query passes
// through S_QWAIT while the level unit reads its tables, then S_FIN puts
// its result beat out. Throughput is one command at a time.
// Reset: synchronous, active low. After reset the order table is cleared
// in one pass over its slots with busy high; level tables and counts
// start empty.
// ----------------------------------------------------------------------------
module price_level_order_book_unit import plob_pkg::*; #(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
    parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_order_id,
    input  logic [63:0] i_new_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [7:0]  i_level_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_exec_side,
    output logic [31:0] o_exec_price,
    output logic [63:0] o_level_remaining,
    output logic [31:0] o_bid_price_out,
    output logic [63:0] o_bid_size_out,
    output logic [31:0] o_ask_price_out,
    output logic [63:0] o_ask_size_out,
    output logic [31:0] o_mid_price,
    output logic [8:0]  o_bid_count,
    output logic [8:0]  o_ask_count,
    output logic [10:0] o_order_total
);

    localparam int OAW = $clog2(ORDER_SLOTS);
    localparam int OCW = $clog2(ORDER_SLOTS + 1);
    localparam int LCW = $clog2(MAX_LEVELS + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_AFTER = 4'd4;
    localparam logic [3:0] S_DWAIT = 4'd5;
    localparam logic [3:0] S_RWAIT = 4'd6;
    localparam logic [3:0] S_AWAIT = 4'd7;
    localparam logic [3:0] S_QWAIT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    t_order_ent ord_mem [ORDER_SLOTS];
    t_order_ent r_ord_rd, wdata, r_ent, n_ent;
    logic [OAW-1:0] waddr;
    logic           we;

    logic [3:0]     r_state, n_state;
    logic [2:0]     r_cmd, n_cmd;
    logic [63:0]    r_key, n_key, r_new_id, n_new_id;
    logic           r_side, n_side;
    logic [31:0]    r_price, n_price, r_qty, n_qty, r_newq, n_newq;
    logic [7:0]     r_idx, n_idx;
    logic           r_phase2, n_phase2, r_miss, n_miss;
    logic           r_found, n_found, r_free_ok, n_free_ok;
    logic [OAW-1:0] r_optr, n_optr, r_slot, n_slot, r_free, n_free;
    logic [OCW-1:0] r_ocnt, n_ocnt;
    logic [1:0]     r_status, n_status;
    logic           r_exec_side, n_exec_side;
    logic [31:0]    r_exec_price, n_exec_price;
    logic [63:0]    r_left, n_left;
    t_lvl_qry       r_qry, n_qry;

    t_lvl_req       lreq;
    t_lvl_rsp       lrsp;
    t_lvl_qry       lqry;
    logic [LCW-1:0] bid_cnt, ask_cnt;
    logic           is_add;
    logic [31:0]    red;

    assign is_add = (r_cmd == CMD_ADD) || ((r_cmd == CMD_REPLACE) && r_phase2);
    assign red    = (r_qty < r_ent.qty) ? r_qty : r_ent.qty;

    plob_level_unit #(.MAX_LEVELS(MAX_LEVELS)) u_level (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (lreq),
        .o_rsp     (lrsp),
        .o_qry     (lqry),
        .o_bid_cnt (bid_cnt),
        .o_ask_cnt (ask_cnt)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_new_id     = r_new_id;
        n_side       = r_side;
        n_price      = r_price;
        n_qty        = r_qty;
        n_newq       = r_newq;
        n_idx        = r_idx;
        n_phase2     = r_phase2;
        n_miss       = r_miss;
        n_found      = r_found;
        n_free_ok    = r_free_ok;
        n_optr       = r_optr;
        n_slot       = r_slot;
        n_free       = r_free;
        n_ent        = r_ent;
        n_ocnt       = r_ocnt;
        n_status     = r_status;
        n_exec_side  = r_exec_side;
        n_exec_price = r_exec_price;
        n_left       = r_left;
        n_qry        = r_qry;
        lreq         = '{op: LOP_NONE, side: r_side, price: r_price,
                         amount: r_qty, idx: r_idx};
        we           = 1'b0;
        waddr        = r_slot;
        wdata        = '{valid: 1'b0, id: r_key, side: r_side,
                         price: r_price, qty: r_qty};
        unique case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_optr;
                if (r_optr == OAW'(ORDER_SLOTS - 1)) begin
                    n_optr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_optr = r_optr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd        = i_command;
                    n_key        = i_order_id;
                    n_new_id     = i_new_order_id;
                    n_side       = i_side;
                    n_price      = i_price;
                    n_qty        = i_quantity;
                    n_idx        = i_level_index;
                    n_phase2     = 1'b0;
                    n_miss       = 1'b0;
                    n_found      = 1'b0;
                    n_free_ok    = 1'b0;
                    n_optr       = '0;
                    n_status     = STAT_OK;
                    n_exec_side  = 1'b0;
                    n_exec_price = 32'd0;
                    n_left       = 64'd0;
                    n_qry        = '0;
                    if (i_command == CMD_QUERY) begin
                        lreq.op  = LOP_READ;
                        lreq.idx = i_level_index;
                        n_state  = S_QWAIT;
                    end else if (i_command > CMD_QUERY) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                if (r_ord_rd.valid && (r_ord_rd.id == r_key)) begin
                    n_found = 1'b1;
                    n_slot  = r_optr;
                    n_ent   = r_ord_rd;
                    n_state = S_AFTER;
                end else begin
                    if (!r_ord_rd.valid && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_optr;
                    end
                    if (r_optr == OAW'(ORDER_SLOTS - 1)) begin
                        n_state = S_AFTER;
                    end else begin
                        n_optr  = r_optr + 1'b1;
                        n_state = S_SRD;
                    end
                end
            end
            S_AFTER: begin
                priority if (is_add) begin
                    if (r_found || !r_free_ok) begin
                        n_status = STAT_ORD_FULL;
                        n_state  = S_FIN;
                    end else begin
                        lreq.op = LOP_ADD;
                        n_state = S_AWAIT;
                    end
                end else if (r_cmd == CMD_REPLACE) begin
                    if (r_found) begin
                        lreq.op     = LOP_TAKE;
                        lreq.side   = r_ent.side;
                        lreq.price  = r_ent.price;
                        lreq.amount = r_ent.qty;
                        n_state     = S_DWAIT;
                    end else begin
                        n_miss    = 1'b1;
                        n_phase2  = 1'b1;
                        n_key     = r_new_id;
                        n_optr    = '0;
                        n_free_ok = 1'b0;
                        n_state   = S_SRD;
                    end
                end else if (!r_found) begin
                    n_status = STAT_UNKNOWN;
                    n_state  = S_FIN;
                end else if (r_cmd == CMD_DELETE) begin
                    lreq.op     = LOP_TAKE;
                    lreq.side   = r_ent.side;
                    lreq.price  = r_ent.price;
                    lreq.amount = r_ent.qty;
                    n_state     = S_DWAIT;
                end else begin
                    lreq.op     = LOP_TAKE;
                    lreq.side   = r_ent.side;
                    lreq.price  = r_ent.price;
                    lreq.amount = red;
                    n_newq      = r_ent.qty - red;
                    n_state     = S_RWAIT;
                end
            end
            S_DWAIT: begin
                if (lrsp.done) begin
                    we     = 1'b1;
                    n_ocnt = r_ocnt - 1'b1;
                    if (r_cmd == CMD_REPLACE) begin
                        n_phase2  = 1'b1;
                        n_key     = r_new_id;
                        n_optr    = '0;
                        n_found   = 1'b0;
                        n_free_ok = 1'b0;
                        n_state   = S_SRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RWAIT: begin
                if (lrsp.done) begin
                    we    = 1'b1;
                    wdata = r_ent;
                    if (r_newq == 32'd0) begin
                        wdata.valid = 1'b0;
                        n_ocnt      = r_ocnt - 1'b1;
                    end else begin
                        wdata.qty = r_newq;
                    end
                    if (r_cmd == CMD_EXECUTE) begin
                        n_exec_side  = r_ent.side;
                        n_exec_price = r_ent.price;
                        n_left       = lrsp.left;
                    end
                    n_state = S_FIN;
                end
            end
            S_AWAIT: begin
                if (lrsp.done) begin
                    if (lrsp.full) begin
                        n_status = STAT_LVL_FULL;
                    end else begin
                        we          = 1'b1;
                        waddr       = r_free;
                        wdata.valid = 1'b1;
                        n_ocnt      = r_ocnt + 1'b1;
                        n_status    = r_miss ? STAT_UNKNOWN : STAT_OK;
                    end
                    n_state = S_FIN;
                end
            end
            S_QWAIT: begin
                if (lrsp.done) begin
                    n_qry   = lqry;
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ord_rd <= ord_mem[r_optr];
        if (we) ord_mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_optr  <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_optr  <= n_optr;
            r_ocnt  <= n_ocnt;
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_new_id     <= n_new_id;
        r_side       <= n_side;
        r_price      <= n_price;
        r_qty        <= n_qty;
        r_newq       <= n_newq;
        r_idx        <= n_idx;
        r_phase2     <= n_phase2;
        r_miss       <= n_miss;
        r_found      <= n_found;
        r_free_ok    <= n_free_ok;
        r_slot       <= n_slot;
        r_free       <= n_free;
        r_ent        <= n_ent;
        r_status     <= n_status;
        r_exec_side  <= n_exec_side;
        r_exec_price <= n_exec_price;
        r_left       <= n_left;
        r_qry        <= n_qry;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_FIN);
    assign o_status          = r_status;
    assign o_exec_side       = r_exec_side;
    assign o_exec_price      = r_exec_price;
    assign o_level_remaining = r_left;
    assign o_bid_price_out   = r_qry.bid_px;
    assign o_bid_size_out    = r_qry.bid_sz;
    assign o_ask_price_out   = r_qry.ask_px;
    assign o_ask_size_out    = r_qry.ask_sz;
    assign o_mid_price       = r_qry.mid;
    assign o_bid_count       = 9'(bid_cnt);
    assign o_ask_count       = 9'(ask_cnt);
    assign o_order_total     = 11'(r_ocnt);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ocnt) <= ORDER_SLOTS)
        else $error("resting order count out of range");

    a_lvl_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lrsp.done |-> (r_state == S_DWAIT || r_state == S_RWAIT ||
                       r_state == S_AWAIT || r_state == S_QWAIT))
        else $error("level unit finished outside a wait state");

endmodule

// File: hdl/plob_level_unit.sv
// ----------------------------------------------------------------------------
// plob_level_unit
// Sorted bid and ask level tables with a walking search, shift insert and
// shift remove, one table entry per step.
// ----------------------------------------------------------------------------
module plob_level_unit import plob_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int LAW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int LCW = $clog2(MAX_LEVELS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_lvl_req       i_req,
    output t_lvl_rsp       o_rsp,
    output t_lvl_qry       o_qry,
    output logic [LCW-1:0] o_bid_cnt,
    output logic [LCW-1:0] o_ask_cnt
);

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_SCAN = 4'd1;
    localparam logic [3:0] L_CHK  = 4'd2;
    localparam logic [3:0] L_RES  = 4'd3;
    localparam logic [3:0] L_SUP  = 4'd4;
    localparam logic [3:0] L_SUW  = 4'd5;
    localparam logic [3:0] L_SDN  = 4'd6;
    localparam logic [3:0] L_SDW  = 4'd7;
    localparam logic [3:0] L_QRY  = 4'd8;

    t_level_ent bid_mem [MAX_LEVELS];
    t_level_ent ask_mem [MAX_LEVELS];
    t_level_ent r_bid_rd, r_ask_rd, cur_rd, wdata;

    logic [3:0]     r_state, n_state;
    t_lvl_req       r_req, n_req;
    logic [LCW-1:0] r_ptr, n_ptr, r_pos, n_pos;
    logic           r_found, n_found;
    logic [63:0]    r_size, n_size;
    logic [LCW-1:0] r_bid_cnt, n_bid_cnt, r_ask_cnt, n_ask_cnt;
    t_lvl_rsp       r_rsp, n_rsp;
    t_lvl_qry       r_qry, n_qry;

    logic [LAW-1:0] rd_addr, waddr;
    logic           we;
    logic [LCW-1:0] cur_cnt, ptr_inc, ptr_dec;
    logic [63:0]    amt64, take_left;
    logic           passed;

    assign cur_cnt   = r_req.side ? r_ask_cnt : r_bid_cnt;
    assign cur_rd    = r_req.side ? r_ask_rd : r_bid_rd;
    assign ptr_inc   = r_ptr + 1'b1;
    assign ptr_dec   = r_ptr - 1'b1;
    assign amt64     = 64'(r_req.amount);
    assign take_left = (r_size >= amt64) ? (r_size - amt64) : 64'd0;
    assign passed    = r_req.side ? (cur_rd.price > r_req.price)
                                  : (cur_rd.price < r_req.price);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_found   = r_found;
        n_size    = r_size;
        n_bid_cnt = r_bid_cnt;
        n_ask_cnt = r_ask_cnt;
        n_rsp     = r_rsp;
        n_rsp.done = 1'b0;
        n_qry     = r_qry;
        rd_addr   = r_ptr[LAW-1:0];
        we        = 1'b0;
        waddr     = r_pos[LAW-1:0];
        wdata     = '{price: r_req.price, size: 64'd0};
        unique case (r_state)
            L_IDLE: begin
                if (i_req.op != LOP_NONE) begin
                    n_req = i_req;
                    n_ptr = '0;
                    if (i_req.op == LOP_READ) begin
                        rd_addr = LAW'(i_req.idx);
                        n_state = L_QRY;
                    end else begin
                        n_state = L_SCAN;
                    end
                end
            end
            L_SCAN: begin
                if (r_ptr == cur_cnt) begin
                    n_found = 1'b0;
                    n_pos   = cur_cnt;
                    n_state = L_RES;
                end else begin
                    n_state = L_CHK;
                end
            end
            L_CHK: begin
                if (cur_rd.price == r_req.price) begin
                    n_found = 1'b1;
                    n_pos   = r_ptr;
                    n_size  = cur_rd.size;
                    n_state = L_RES;
                end else if (passed) begin
                    n_found = 1'b0;
                    n_pos   = r_ptr;
                    n_state = L_RES;
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = L_SCAN;
                end
            end
            L_RES: begin
                n_rsp.full = 1'b0;
                n_rsp.left = 64'd0;
                if (r_req.op == LOP_TAKE) begin
                    if (!r_found) begin
                        n_rsp.done = 1'b1;
                        n_state    = L_IDLE;
                    end else if (take_left != 64'd0) begin
                        we         = 1'b1;
                        wdata.size = take_left;
                        n_rsp.left = take_left;
                        n_rsp.done = 1'b1;
                        n_state    = L_IDLE;
                    end else begin
                        n_ptr   = r_pos;
                        n_state = L_SUP;
                    end
                end else if (r_found) begin
                    we         = 1'b1;
                    wdata.size = r_size + amt64;
                    n_rsp.done = 1'b1;
                    n_state    = L_IDLE;
                end else if (cur_cnt == LCW'(MAX_LEVELS)) begin
                    n_rsp.full = 1'b1;
                    n_rsp.done = 1'b1;
                    n_state    = L_IDLE;
                end else begin
                    n_ptr   = cur_cnt;
                    n_state = L_SDN;
                end
            end
            L_SUP: begin
                rd_addr = ptr_inc[LAW-1:0];
                if (ptr_inc >= cur_cnt) begin
                    if (r_req.side) n_ask_cnt = r_ask_cnt - 1'b1;
                    else            n_bid_cnt = r_bid_cnt - 1'b1;
                    n_rsp.done = 1'b1;
                    n_state    = L_IDLE;
                end else begin
                    n_state = L_SUW;
                end
            end
            L_SUW: begin
                we      = 1'b1;
                waddr   = r_ptr[LAW-1:0];
                wdata   = cur_rd;
                n_ptr   = ptr_inc;
                n_state = L_SUP;
            end
            L_SDN: begin
                rd_addr = ptr_dec[LAW-1:0];
                if (r_ptr == r_pos) begin
                    we         = 1'b1;
                    wdata.size = amt64;
                    if (r_req.side) n_ask_cnt = r_ask_cnt + 1'b1;
                    else            n_bid_cnt = r_bid_cnt + 1'b1;
                    n_rsp.done = 1'b1;
                    n_state    = L_IDLE;
                end else begin
                    n_state = L_SDW;
                end
            end
            L_SDW: begin
                we      = 1'b1;
                waddr   = r_ptr[LAW-1:0];
                wdata   = cur_rd;
                n_ptr   = ptr_dec;
                n_state = L_SDN;
            end
            L_QRY: begin
                n_qry.bid_px = 32'd0;
                n_qry.bid_sz = 64'd0;
                n_qry.ask_px = ASK_EMPTY;
                n_qry.ask_sz = 64'd0;
                if (32'(r_req.idx) < 32'(r_bid_cnt)) begin
                    n_qry.bid_px = r_bid_rd.price;
                    n_qry.bid_sz = r_bid_rd.size;
                end
                if (32'(r_req.idx) < 32'(r_ask_cnt)) begin
                    n_qry.ask_px = r_ask_rd.price;
                    n_qry.ask_sz = r_ask_rd.size;
                end
                n_qry.mid  = 32'((33'(n_qry.bid_px) + 33'(n_qry.ask_px)) >> 1);
                n_rsp.done = 1'b1;
                n_state    = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bid_rd <= bid_mem[rd_addr];
        r_ask_rd <= ask_mem[rd_addr];
        if (we && !r_req.side) bid_mem[waddr] <= wdata;
        if (we && r_req.side)  ask_mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= L_IDLE;
            r_bid_cnt <= '0;
            r_ask_cnt <= '0;
            r_rsp     <= '0;
        end else begin
            r_state   <= n_state;
            r_bid_cnt <= n_bid_cnt;
            r_ask_cnt <= n_ask_cnt;
            r_rsp     <= n_rsp;
        end
        r_req   <= n_req;
        r_ptr   <= n_ptr;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_size  <= n_size;
        r_qry   <= n_qry;
    end

    assign o_rsp     = r_rsp;
    assign o_qry     = r_qry;
    assign o_bid_cnt = r_bid_cnt;
    assign o_ask_cnt = r_ask_cnt;

endmodule

// File: dv/price_level_order_book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_checker
// Watches the command and result beats of the order book. It keeps its own
// copy of the order table and both price-level tables, predicts every result
// and compares it field by field with the beat that the block returns.
// ----------------------------------------------------------------------------
module price_level_order_book_checker import plob_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_order_id,
    input  logic [63:0] i_new_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic [7:0]  i_level_index,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic        o_exec_side,
    input  logic [31:0] o_exec_price,
    input  logic [63:0] o_level_remaining,
    input  logic [31:0] o_bid_price_out,
    input  logic [63:0] o_bid_size_out,
    input  logic [31:0] o_ask_price_out,
    input  logic [63:0] o_ask_size_out,
    input  logic [31:0] o_mid_price,
    input  logic [8:0]  o_bid_count,
    input  logic [8:0]  o_ask_count,
    input  logic [10:0] o_order_total,
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        logic [1:0]  status;
        logic        exec_side;
        logic [31:0] exec_price;
        logic [63:0] level_remaining;
        logic [31:0] bid_px;
        logic [63:0] bid_sz;
        logic [31:0] ask_px;
        logic [63:0] ask_sz;
        logic [31:0] mid;
        logic [8:0]  bid_count;
        logic [8:0]  ask_count;
        logic [10:0] order_total;
    } t_book_result;

    bit          ord_valid [ORDER_SLOTS_DEF];
    logic [63:0] ord_id    [ORDER_SLOTS_DEF];
    logic        ord_side  [ORDER_SLOTS_DEF];
    logic [31:0] ord_price [ORDER_SLOTS_DEF];
    logic [31:0] ord_qty   [ORDER_SLOTS_DEF];
    logic [31:0] lvl_price [2][MAX_LEVELS_DEF];
    logic [63:0] lvl_size  [2][MAX_LEVELS_DEF];
    int          lvl_cnt   [2];
    int          resting;

    t_book_result result_q[$];

    assign o_pending = result_q.size();

    function automatic int find_order(logic [63:0] id);
        for (int i = 0; i < ORDER_SLOTS_DEF; i++)
            if (ord_valid[i] && ord_id[i] == id) return i;
        return -1;
    endfunction

    function automatic bit find_level(logic s, logic [31:0] p, output int pos);
        for (int i = 0; i < lvl_cnt[s]; i++) begin
            if (lvl_price[s][i] == p) begin
                pos = i;
                return 1;
            end
            if (s == 0 ? (lvl_price[s][i] < p) : (lvl_price[s][i] > p)) begin
                pos = i;
                return 0;
            end
        end
        pos = lvl_cnt[s];
        return 0;
    endfunction

    function automatic logic [63:0] level_take(logic s, logic [31:0] p,
                                               logic [63:0] amount);
        int pos;
        logic [63:0] left;
        if (!find_level(s, p, pos)) return 64'd0;
        left = lvl_size[s][pos] >= amount ? lvl_size[s][pos] - amount : 64'd0;
        lvl_size[s][pos] = left;
        if (left == 0) begin
            for (int i = pos; i < lvl_cnt[s] - 1; i++) begin
                lvl_price[s][i] = lvl_price[s][i+1];
                lvl_size[s][i]  = lvl_size[s][i+1];
            end
            lvl_cnt[s]--;
        end
        return left;
    endfunction

    function automatic void drop_order(int slot);
        void'(level_take(ord_side[slot], ord_price[slot], {32'd0, ord_qty[slot]}));
        ord_valid[slot] = 0;
        resting--;
    endfunction

    function automatic logic [1:0] add_order(logic [63:0] id, logic s,
                                             logic [31:0] p, logic [31:0] q);
        int slot;
        int pos;
        slot = -1;
        if (find_order(id) >= 0) return STAT_ORD_FULL;
        for (int i = 0; i < ORDER_SLOTS_DEF; i++)
            if (!ord_valid[i]) begin
                slot = i;
                break;
            end
        if (slot < 0) return STAT_ORD_FULL;
        if (!find_level(s, p, pos)) begin
            if (lvl_cnt[s] >= MAX_LEVELS_DEF) return STAT_LVL_FULL;
            for (int i = lvl_cnt[s]; i > pos; i--) begin
                lvl_price[s][i] = lvl_price[s][i-1];
                lvl_size[s][i]  = lvl_size[s][i-1];
            end
            lvl_price[s][pos] = p;
            lvl_size[s][pos]  = 64'd0;
            lvl_cnt[s]++;
        end
        lvl_size[s][pos] += {32'd0, q};
        ord_valid[slot] = 1;
        ord_id[slot]    = id;
        ord_side[slot]  = s;
        ord_price[slot] = p;
        ord_qty[slot]   = q;
        resting++;
        return STAT_OK;
    endfunction

    function automatic t_book_result predict_book(logic [2:0] cmd, logic [63:0] id,
            logic [63:0] new_id, logic s, logic [31:0] p, logic [31:0] q,
            logic [7:0] idx);
        t_book_result r;
        int slot;
        logic [31:0] take;
        logic [63:0] left;
        r = '{default: '0};
        r.ask_px = '0;
        case (cmd)
            CMD_ADD: r.status = add_order(id, s, p, q);
            CMD_REPLACE: begin
                slot = find_order(id);
                if (slot >= 0) drop_order(slot);
                r.status = add_order(new_id, s, p, q);
                if (r.status == STAT_OK && slot < 0) r.status = STAT_UNKNOWN;
            end
            CMD_CANCEL, CMD_EXECUTE: begin
                slot = find_order(id);
                if (slot < 0) begin
                    r.status = STAT_UNKNOWN;
                end else begin
                    take = q < ord_qty[slot] ? q : ord_qty[slot];
                    ord_qty[slot] -= take;
                    left = level_take(ord_side[slot], ord_price[slot], {32'd0, take});
                    if (cmd == CMD_EXECUTE) begin
                        r.exec_side       = ord_side[slot];
                        r.exec_price      = ord_price[slot];
                        r.level_remaining = left;
                    end
                    if (ord_qty[slot] == 0) drop_order(slot);
                end
            end
            CMD_DELETE: begin
                slot = find_order(id);
                if (slot < 0) r.status = STAT_UNKNOWN;
                else drop_order(slot);
            end
            CMD_QUERY: begin
                r.ask_px = ASK_EMPTY;
                if (idx < lvl_cnt[0]) begin
                    r.bid_px = lvl_price[0][idx];
                    r.bid_sz = lvl_size[0][idx];
                end
                if (idx < lvl_cnt[1]) begin
                    r.ask_px = lvl_price[1][idx];
                    r.ask_sz = lvl_size[1][idx];
                end
                r.mid = 32'(({1'b0, r.bid_px} + {1'b0, r.ask_px}) >> 1);
            end
            default: ;
        endcase
        r.bid_count   = 9'(lvl_cnt[0]);
        r.ask_count   = 9'(lvl_cnt[1]);
        r.order_total = 11'(resting);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        resting  = 0;
        lvl_cnt  = '{0, 0};
        foreach (ord_valid[i]) ord_valid[i] = 0;
    end

    always @(posedge i_clk) begin
        t_book_result e;
        if (i_rst_n) begin
            if (o_valid) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_errors++;
                end else begin
                    e = result_q.pop_front();
                    check_field("status", 64'(e.status), 64'(o_status));
                    check_field("exec_side", 64'(e.exec_side), 64'(o_exec_side));
                    check_field("exec_price", 64'(e.exec_price), 64'(o_exec_price));
                    check_field("level_remaining", e.level_remaining, o_level_remaining);
                    check_field("bid_price_out", 64'(e.bid_px), 64'(o_bid_price_out));
                    check_field("bid_size_out", e.bid_sz, o_bid_size_out);
                    check_field("ask_price_out", 64'(e.ask_px), 64'(o_ask_price_out));
                    check_field("ask_size_out", e.ask_sz, o_ask_size_out);
                    check_field("mid_price", 64'(e.mid), 64'(o_mid_price));
                    check_field("bid_count", 64'(e.bid_count), 64'(o_bid_count));
                    check_field("ask_count", 64'(e.ask_count), 64'(o_ask_count));
                    check_field("order_total", 64'(e.order_total), 64'(o_order_total));
                end
            end
            if (start && !busy)
                result_q.push_back(predict_book(i_command, i_order_id, i_new_order_id,
                    i_side, i_price, i_quantity, i_level_index));
        end
    end

endmodule

// File: dv/price_level_order_book_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_unit_tb
// Drives directed and random command beats into the order book in bursts
// with random gaps, including a fill of the order table and the bid level table, while
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module price_level_order_book_unit_tb;
    import plob_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_command;
    logic [63:0] i_order_id;
    logic [63:0] i_new_order_id;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_quantity;
    logic [7:0]  i_level_index;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_exec_side;
    logic [31:0] o_exec_price;
    logic [63:0] o_level_remaining;
    logic [31:0] o_bid_price_out;
    logic [63:0] o_bid_size_out;
    logic [31:0] o_ask_price_out;
    logic [63:0] o_ask_size_out;
    logic [31:0] o_mid_price;
    logic [8:0]  o_bid_count;
    logic [8:0]  o_ask_count;
    logic [10:0] o_order_total;
    int          errors;
    int          pending;

    logic [63:0] id_pool [48];
    logic [31:0] price_pool [12];
    int          burst_left;

    price_level_order_book_unit i_dut (.*);

    price_level_order_book_checker i_checker (.*, .o_errors(errors), .o_pending(pending));

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #500_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_cmd(logic [2:0] cmd, logic [63:0] id, logic [63:0] new_id,
                            logic s, logic [31:0] p, logic [31:0] q, logic [7:0] idx);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_order_id     <= id;
        i_new_order_id <= new_id;
        i_side         <= s;
        i_price        <= p;
        i_quantity     <= q;
        i_level_index  <= idx;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    task automatic send_random();
        logic [2:0]  cmd;
        logic [63:0] id;
        logic [63:0] new_id;
        logic [31:0] p;
        logic [7:0]  idx;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: cmd = CMD_ADD;
            6, 7:             cmd = CMD_REPLACE;
            8, 9:             cmd = CMD_CANCEL;
            10, 11, 12:       cmd = CMD_EXECUTE;
            13, 14:           cmd = CMD_DELETE;
            15, 16, 17:       cmd = CMD_QUERY;
            default:          cmd = 3'($urandom_range(0, 7));
        endcase
        id     = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                             : id_pool[$urandom_range(0, 47)];
        new_id = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                             : id_pool[$urandom_range(0, 47)];
        p      = ($urandom_range(0, 7) == 0) ? $urandom : price_pool[$urandom_range(0, 11)];
        idx    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        send_cmd(cmd, id, new_id, 1'($urandom), p, pick_qty(), idx);
    endtask

    initial begin
        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_command      <= CMD_ADD;
        i_order_id     <= '0;
        i_new_order_id <= '0;
        i_side         <= 1'b0;
        i_price        <= '0;
        i_quantity     <= '0;
        i_level_index  <= '0;
        burst_left      = 0;
        id_pool[0]      = 64'd0;
        id_pool[1]      = '1;
        for (int i = 2; i < 48; i++) id_pool[i] = {$urandom, $urandom};
        price_pool[0]   = 32'd0;
        price_pool[1]   = 32'hFFFF_FFFF;
        for (int i = 2; i < 12; i++) price_pool[i] = 32'd1000 + 32'(i);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(CMD_ADD, 64'd0, 64'd0, 1'b0, 32'd100, 32'd0, 8'd0);
        send_cmd(CMD_ADD, 64'd0, 64'd0, 1'b0, 32'd100, 32'd5, 8'd0);
        send_cmd(CMD_ADD, '1, 64'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_cmd(CMD_ADD, 64'd7, 64'd0, 1'b0, 32'd0, 32'd9, 8'd0);
        send_cmd(CMD_ADD, 64'd8, 64'd0, 1'b1, 32'd200, 32'd4, 8'd0);
        send_cmd(CMD_QUERY, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_QUERY, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0, 8'd255);
        send_cmd(CMD_REPLACE, 64'd55, 64'd9, 1'b1, 32'd201, 32'd3, 8'd0);
        send_cmd(CMD_REPLACE, 64'd9, 64'd10, 1'b0, 32'd100, 32'd6, 8'd0);
        send_cmd(CMD_EXECUTE, 64'd10, 64'd0, 1'b0, 32'd0, 32'd6, 8'd0);
        send_cmd(CMD_EXECUTE, 64'd0, 64'd0, 1'b0, 32'd0, 32'd1, 8'd0);
        send_cmd(CMD_EXECUTE, 64'd8, 64'd0, 1'b0, 32'd0, 32'd2, 8'd0);
        send_cmd(CMD_CANCEL, 64'd8, 64'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 8'd0);
        send_cmd(CMD_EXECUTE, '1, 64'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 8'd0);
        send_cmd(CMD_DELETE, 64'd77, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_CANCEL, 64'd77, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_DELETE, 64'd7, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_RSV_A, 64'd1, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_RSV_B, 64'd1, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);
        send_cmd(CMD_QUERY, 64'd0, 64'd0, 1'b0, 32'd0, 32'd0, 8'd0);

        repeat (250) send_random();

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int i = 0; i < 1040; i++)
            send_cmd(CMD_ADD, {16'hF11F, 48'(i)}, 64'd0, 1'b0, 32'($urandom_range(1, 300)),
                     32'($urandom_range(1, 50)), 8'd0);
        repeat (40) send_random();

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: price_level_order_book_unit.f
hdl/plob_pkg.sv
hdl/plob_level_unit.sv
hdl/price_level_order_book_unit.sv
dv/price_level_order_book_checker.sv
dv/price_level_order_book_unit_tb.sv
